>>> design/rgb_brightness_rescale_top_assert.svh
// Assertion macros used by the checker of the brightness rescaler.
`ifndef RGB_BRIGHTNESS_RESCALE_TOP_ASSERT_SVH
`define RGB_BRIGHTNESS_RESCALE_TOP_ASSERT_SVH

// Overlapping implication, sampled on clk and switched off while rst_n is low.
`define RGBBR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RGBBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rgbbr_pkg.sv
// Types and constants shared by the brightness rescaler modules.
package rgbbr_pkg;

    localparam int CHAN_W  = 8;
    localparam int LVL_W   = 7;
    localparam int PROD_W  = LVL_W + CHAN_W;
    localparam int NUM_W   = PROD_W + CHAN_W;
    localparam int DEN_W   = 15;
    localparam int QUO_W   = CHAN_W;
    localparam int LANES   = 3;

    // One stage for the numerator, then one stage per quotient bit.
    localparam int LANE_DEPTH = QUO_W + 1;
    // Front register, lane stages and output register, counted start to strobe.
    localparam int LATENCY    = LANE_DEPTH + 2;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [LVL_W-1:0]  lvl_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [DEN_W-1:0]  den_t;

    localparam lvl_t LEVEL_MIN     = 7'd1;
    localparam lvl_t LEVEL_MAX     = 7'd100;
    localparam num_t FULL_SCALE    = 23'd255;
    localparam den_t PERCENT_SCALE = 15'd100;

endpackage

>>> design/rgb_brightness_rescale_top.sv
// Top level of the RGB brightness rescaler.
//
// The block takes one 8-bit RGB pixel and a brightness level in percent and
// returns the pixel with the same channel ratios, scaled so that its largest
// channel becomes level/100 of full scale. The level is clamped to 1..100;
// a black pixel comes back as a grey of that brightness on all channels.
//
// Input: a beat is taken at each rising edge where start is high and busy is
// low. busy is high while rst_n is asserted and until the first clock edge
// after its release, so a new pixel may follow in every cycle.
// Output: done is high for exactly one cycle with red_out, green_out and
// blue_out valid; the receiver cannot hold results off and needs none.
//
// Throughput is one pixel per clock. The result passes the front stage
// (clamp, maximum, products), the numerator stage, the per-channel
// restoring divider with one quotient bit per stage, and the output
// register. Three identical lanes run side by side, one per channel.
// Reset clears every valid flag, so beats in flight at reset are dropped.
module rgb_brightness_rescale_top
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rgbbr_pkg::chan_t red_in,
    input  rgbbr_pkg::chan_t green_in,
    input  rgbbr_pkg::chan_t blue_in,
    input  rgbbr_pkg::chan_t level_percent,
    output logic             done,
    output rgbbr_pkg::chan_t red_out,
    output rgbbr_pkg::chan_t green_out,
    output rgbbr_pkg::chan_t blue_out
);

    logic                                    busy_reg;
    logic                                    accept;
    logic                                    front_vld;
    rgbbr_pkg::prod_t [rgbbr_pkg::LANES-1:0] prod;
    rgbbr_pkg::den_t                         den;
    rgbbr_pkg::chan_t [rgbbr_pkg::LANES-1:0] quo;
    logic [rgbbr_pkg::LANE_DEPTH-1:0]        vld_pipe_reg;
    logic [rgbbr_pkg::LANE_DEPTH-1:0]        vld_pipe_next;

    // Hold off input only while coming out of reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    rgbbr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .level_percent (level_percent),
        .vld           (front_vld),
        .prod          (prod),
        .den           (den)
    );

    // The lanes carry payload only; this shift line tracks which of their
    // stages hold a live pixel.
    assign vld_pipe_next = {vld_pipe_reg[rgbbr_pkg::LANE_DEPTH-2:0], front_vld};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_pipe_reg <= '0;
        else
            vld_pipe_reg <= vld_pipe_next;
    end

    for (genvar i = 0; i < rgbbr_pkg::LANES; i++)
    begin : g_lane
        rgbbr_lane u_lane
        (
            .clk  (clk),
            .prod (prod[i]),
            .den  (den),
            .quo  (quo[i])
        );
    end

    rgbbr_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld       (vld_pipe_reg[rgbbr_pkg::LANE_DEPTH-1]),
        .quo       (quo),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

>>> design/rgbbr_front.sv
// Front stage: level clamp, largest channel and per-lane products.
module rgbbr_front
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         accept,
    input  rgbbr_pkg::chan_t                             red_in,
    input  rgbbr_pkg::chan_t                             green_in,
    input  rgbbr_pkg::chan_t                             blue_in,
    input  rgbbr_pkg::chan_t                             level_percent,
    output logic                                         vld,
    output rgbbr_pkg::prod_t [rgbbr_pkg::LANES-1:0]      prod,
    output rgbbr_pkg::den_t                              den
);

    logic                                    vld_reg;
    rgbbr_pkg::prod_t [rgbbr_pkg::LANES-1:0] prod_reg;
    rgbbr_pkg::prod_t [rgbbr_pkg::LANES-1:0] prod_next;
    rgbbr_pkg::den_t                         den_reg;
    rgbbr_pkg::den_t                         den_next;
    rgbbr_pkg::chan_t [rgbbr_pkg::LANES-1:0] chan;
    rgbbr_pkg::chan_t                        max_chan;
    rgbbr_pkg::chan_t                        mul_chan;
    rgbbr_pkg::lvl_t                         lvl;
    logic                                    max_zero;

    always_comb
    begin
        chan = {blue_in, green_in, red_in};

        if (level_percent < {1'b0, rgbbr_pkg::LEVEL_MIN})
            lvl = rgbbr_pkg::LEVEL_MIN;
        else if (level_percent > {1'b0, rgbbr_pkg::LEVEL_MAX})
            lvl = rgbbr_pkg::LEVEL_MAX;
        else
            lvl = level_percent[rgbbr_pkg::LVL_W-1:0];

        max_chan = red_in;
        if (green_in > max_chan)
            max_chan = green_in;
        if (blue_in > max_chan)
            max_chan = blue_in;
        max_zero = (max_chan == '0);

        // A black pixel turns into level/100 of full scale on every channel,
        // which is the ordinary ratio with both channel and maximum set to one.
        for (int i = 0; i < rgbbr_pkg::LANES; i++)
        begin
            mul_chan     = max_zero ? rgbbr_pkg::chan_t'(1) : chan[i];
            prod_next[i] = rgbbr_pkg::prod_t'(lvl) * rgbbr_pkg::prod_t'(mul_chan);
        end

        den_next = max_zero ? rgbbr_pkg::PERCENT_SCALE
                            : rgbbr_pkg::den_t'(max_chan) * rgbbr_pkg::PERCENT_SCALE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        den_reg  <= den_next;
    end

    assign vld  = vld_reg;
    assign prod = prod_reg;
    assign den  = den_reg;

endmodule

>>> design/rgbbr_lane.sv
// One channel lane: numerator stage and a pipelined restoring divider.
module rgbbr_lane
(
    input  logic             clk,
    input  rgbbr_pkg::prod_t prod,
    input  rgbbr_pkg::den_t  den,
    output rgbbr_pkg::chan_t quo
);

    rgbbr_pkg::num_t  rem_reg  [0:rgbbr_pkg::QUO_W-1];
    rgbbr_pkg::num_t  rem_next [1:rgbbr_pkg::QUO_W-1];
    rgbbr_pkg::num_t  rem_dif  [0:rgbbr_pkg::QUO_W-1];
    rgbbr_pkg::den_t  den_reg  [0:rgbbr_pkg::QUO_W-1];
    rgbbr_pkg::chan_t q_reg    [1:rgbbr_pkg::QUO_W];
    rgbbr_pkg::chan_t q_next   [1:rgbbr_pkg::QUO_W];
    rgbbr_pkg::num_t  num_next;
    rgbbr_pkg::num_t  dsh;
    logic [rgbbr_pkg::QUO_W-1:0] take;

    // Each stage settles one quotient bit, most significant first. The
    // quotient never exceeds full scale, so eight stages are exact.
    always_comb
    begin
        num_next = rgbbr_pkg::num_t'(prod) * rgbbr_pkg::FULL_SCALE;

        for (int s = 0; s < rgbbr_pkg::QUO_W; s++)
        begin
            dsh        = rgbbr_pkg::num_t'(den_reg[s]) << (rgbbr_pkg::QUO_W - 1 - s);
            take[s]    = (rem_reg[s] >= dsh);
            rem_dif[s] = rem_reg[s] - dsh;
        end

        for (int s = 1; s < rgbbr_pkg::QUO_W; s++)
            rem_next[s] = take[s-1] ? rem_dif[s-1] : rem_reg[s-1];

        q_next[1] = rgbbr_pkg::chan_t'(take[0]);
        for (int s = 2; s <= rgbbr_pkg::QUO_W; s++)
            q_next[s] = {q_reg[s-1][rgbbr_pkg::QUO_W-2:0], take[s-1]};
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_next;
        den_reg[0] <= den;
        for (int s = 1; s < rgbbr_pkg::QUO_W; s++)
        begin
            rem_reg[s] <= rem_next[s];
            den_reg[s] <= den_reg[s-1];
        end
        for (int s = 1; s <= rgbbr_pkg::QUO_W; s++)
            q_reg[s] <= q_next[s];
    end

    assign quo = q_reg[rgbbr_pkg::QUO_W];

endmodule

>>> design/rgbbr_merge.sv
// Output stage: gathers the three lane quotients into one result beat.
module rgbbr_merge
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    vld,
    input  rgbbr_pkg::chan_t [rgbbr_pkg::LANES-1:0] quo,
    output logic                                    done,
    output rgbbr_pkg::chan_t                        red_out,
    output rgbbr_pkg::chan_t                        green_out,
    output rgbbr_pkg::chan_t                        blue_out
);

    logic                                    done_reg;
    rgbbr_pkg::chan_t [rgbbr_pkg::LANES-1:0] pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld;
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= quo;
    end

    assign done      = done_reg;
    assign red_out   = pix_reg[0];
    assign green_out = pix_reg[1];
    assign blue_out  = pix_reg[2];

endmodule

>>> design/rgbbr_checker.sv
// Port-level checker for the brightness rescaler and its bind.
`include "rgb_brightness_rescale_top_assert.svh"

module rgbbr_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input rgbbr_pkg::chan_t red_in,
    input rgbbr_pkg::chan_t green_in,
    input rgbbr_pkg::chan_t blue_in,
    input rgbbr_pkg::chan_t level_percent,
    input logic             done,
    input rgbbr_pkg::chan_t red_out,
    input rgbbr_pkg::chan_t green_out,
    input rgbbr_pkg::chan_t blue_out
);

    localparam int LAT = rgbbr_pkg::LATENCY;

    logic beat;
    logic black_full;
    logic red_full;
    logic grey;
    logic white_out;
    logic red_top;
    logic grey_out;

    assign beat       = start && !busy;
    assign black_full = beat && (red_in == '0) && (green_in == '0) && (blue_in == '0)
                        && (level_percent >= 8'd100);
    assign red_full   = beat && (red_in >= green_in) && (red_in >= blue_in)
                        && (level_percent >= 8'd100);
    assign grey       = beat && (red_in == green_in) && (green_in == blue_in);
    assign white_out  = (red_out == 8'd255) && (green_out == 8'd255) && (blue_out == 8'd255);
    assign red_top    = (red_out == 8'd255);
    assign grey_out   = (red_out == green_out) && (green_out == blue_out);

    // Every accepted beat produces a strobe after the fixed latency.
    `RGBBR_ASSERT_IMPL(a_latency, beat, ##LAT done, "result strobe missing")
    // A black pixel at full level comes back as full-scale white.
    `RGBBR_ASSERT_IMPL(a_black_full, black_full, ##LAT white_out, "black pixel not full white")
    // The largest channel at full level reaches full scale.
    `RGBBR_ASSERT_IMPL(a_max_full, red_full, ##LAT red_top, "largest channel below full scale")
    // A grey pixel stays grey.
    `RGBBR_ASSERT_IMPL(a_grey, grey, ##LAT grey_out, "grey pixel lost balance")
    // Once input is open it stays open until the next reset.
    `RGBBR_ASSERT_NEXT(a_busy_low, !busy, !busy, "busy rose outside reset")

endmodule

bind rgb_brightness_rescale_top rgbbr_checker u_rgbbr_checker (.*);
